// File: src/hpscd_pkg.sv
// ----------------------------------------------------------------------------
// hpscd_pkg
// Shared types and constants of the parameter-set change detector.
// ----------------------------------------------------------------------------
`default_nettype none

package hpscd_pkg;

   // default number of bytes kept per parameter set
   localparam int MAX_SET_BYTES_DEF = 256;

   // scan queue between the byte front end and the scanner
   localparam int QUEUE_DEPTH = 8;
   localparam int QIW         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // nal unit types of interest
   localparam logic [5:0] NAL_VPS = 6'd32;
   localparam logic [5:0] NAL_PPS = 6'd34;

   // set index meaning "no set being captured"
   localparam logic [1:0] SET_NONE = 2'd3;

   localparam logic [23:0] SAT24             = 24'hFF_FFFF;
   localparam logic [15:0] SINCE_MAX         = 16'hFFFF;
   localparam logic [7:0]  NAL_CNT_MAX       = 8'hFF;
   localparam logic [7:0]  REPORT_WINDOW_RST = 8'd3;

   // which start code lengths may be tried at the head byte
   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_SHORT,
      MODE_FULL
   } scan_mode_type;

   // one queued byte with its unit tags
   typedef struct packed {
      logic [7:0]  data;
      logic        first;
      logic        last;
      logic        key;
      logic [23:0] size;
      logic [15:0] since;
   } q_entry_type;

   // scanner control for the head byte
   typedef struct packed {
      logic          visit;
      logic          restart;
      logic          finish;
      scan_mode_type mode;
   } scan_ctl_type;

   // unit summary, valid in the cycle of a finishing visit
   typedef struct packed {
      logic [2:0] present;
      logic [2:0] changed;
      logic [7:0] nal_count;
   } scan_sum_type;

   // late byte compare of a finishing visit, in the cycle after it
   typedef struct packed {
      logic       valid;
      logic [2:0] changed;
   } scan_late_type;

endpackage

`default_nettype wire

// File: src/hpscd_scan.sv
// ----------------------------------------------------------------------------
// hpscd_scan
// Start code scanner and parameter-set capture/compare over a byte memory.
// ----------------------------------------------------------------------------
`default_nettype none

module hpscd_scan
   import hpscd_pkg::*;
#(
   parameter int MAX_SET_BYTES = MAX_SET_BYTES_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire scan_ctl_type  ctl,
   input  wire logic [39:0]   window,   // head byte in [39:32], lookahead below
   output scan_sum_type       sum,
   output scan_late_type      late
);

   localparam int KW        = $clog2(MAX_SET_BYTES);
   localparam int MEM_DEPTH = 6 * MAX_SET_BYTES;
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam logic [23:0] SET_LIMIT = 24'(MAX_SET_BYTES);

   typedef struct packed {
      logic       valid;
      logic       finish;
      logic [1:0] set;
      logic [7:0] data;
      logic       beyond;
   } pend_type;

   // two banks per set kind: one stored, one candidate
   logic [7:0] set_mem [MEM_DEPTH];
   logic [7:0] rd_ff;

   pend_type    pend_ff, pend_in;
   logic [2:0]  skip_ff, skip_in;
   logic [1:0]  cur_ff, cur_in;
   logic [2:0]  pres_ff, pres_in;
   logic [2:0]  mis_ff, mis_in;
   logic [7:0]  nal_ff, nal_in;
   logic [23:0] cand_len_ff [3];
   logic [23:0] cand_len_in [3];
   logic [23:0] stored_len_ff [3];
   logic [23:0] stored_len_in [3];
   logic [2:0]  sel_ff, sel_in;

   logic          mem_we;
   logic [AW-1:0] waddr, raddr;
   logic [7:0]    wdata;
   logic          res_hit;
   logic [2:0]    res_mask;
   logic [7:0]    b0, b1, b2, b3, b4;

   assign b0 = window[39:32];
   assign b1 = window[31:24];
   assign b2 = window[23:16];
   assign b3 = window[15:8];
   assign b4 = window[7:0];

   // resolve the compare issued last cycle
   always_comb begin
      res_hit      = pend_ff.valid & (pend_ff.beyond | (rd_ff != pend_ff.data));
      res_mask     = res_hit ? (3'b001 << pend_ff.set) : 3'b000;
      late.valid   = pend_ff.valid & pend_ff.finish;
      late.changed = res_mask;
   end

   // visit of the head byte
   always_comb begin
      logic [2:0]  skip_v;
      logic [1:0]  cur_v;
      logic [2:0]  pres_v;
      logic [2:0]  mis_v;
      logic [7:0]  nal_v;
      logic [23:0] len_v [3];
      logic        app;
      logic        code3;
      logic        code4;
      logic [7:0]  hdr;
      logic [5:0]  t6;
      logic [1:0]  s_new;
      logic [23:0] k;
      logic [2:0]  slot_w;
      logic [2:0]  slot_r;

      mis_v  = mis_ff | (pend_ff.finish ? 3'b000 : res_mask);
      skip_v = skip_ff;
      cur_v  = cur_ff;
      pres_v = pres_ff;
      nal_v  = nal_ff;
      len_v  = cand_len_ff;
      app    = 1'b0;
      code3  = 1'b0;
      code4  = 1'b0;
      hdr    = 8'd0;
      t6     = 6'd0;
      s_new  = 2'd0;
      k      = 24'd0;
      slot_w = 3'd0;
      slot_r = 3'd0;
      mem_we = 1'b0;
      waddr  = '0;
      raddr  = '0;
      wdata  = b0;
      pend_in = '0;

      // a first-of-unit byte starts from a clean unit
      if (ctl.visit && ctl.restart) begin
         skip_v = 3'd0;
         cur_v  = SET_NONE;
         pres_v = 3'b000;
         mis_v  = 3'b000;
         nal_v  = 8'd0;
         len_v  = '{default: 24'd0};
      end

      if (ctl.visit) begin
         if (skip_v != 3'd0) begin
            // rest of the start code is skipped; both nal header bytes are kept
            app    = (skip_v <= 3'd2);
            skip_v = skip_v - 3'd1;
         end else begin
            code3 = (ctl.mode != MODE_NONE) && b0 == 8'd0 && b1 == 8'd0 && b2 == 8'd1;
            code4 = (ctl.mode == MODE_FULL) && b0 == 8'd0 && b1 == 8'd0 && b2 == 8'd0
                    && b3 == 8'd1;
            if (code3 || code4) begin
               if (nal_v != NAL_CNT_MAX)
                  nal_v = nal_v + 8'd1;
               hdr   = code3 ? b3 : b4;
               t6    = hdr[6:1];
               cur_v = SET_NONE;
               if (t6 >= NAL_VPS && t6 <= NAL_PPS) begin
                  s_new = 2'(t6 - NAL_VPS);
                  if (!pres_v[s_new]) begin
                     pres_v[s_new] = 1'b1;
                     len_v[s_new]  = 24'd0;
                     mis_v[s_new]  = 1'b0;
                     cur_v         = s_new;
                  end
               end
               skip_v = code3 ? 3'd4 : 3'd5;
            end else begin
               app = 1'b1;
            end
         end

         // append to the set being captured and compare with the stored one
         if (app && cur_v != SET_NONE) begin
            k = len_v[cur_v];
            if (k < SET_LIMIT) begin
               slot_w  = {1'b0, cur_v} + (sel_ff[cur_v] ? 3'd0 : 3'd3);
               slot_r  = {1'b0, cur_v} + (sel_ff[cur_v] ? 3'd3 : 3'd0);
               waddr   = AW'(slot_w * MAX_SET_BYTES) + AW'(k[KW-1:0]);
               raddr   = AW'(slot_r * MAX_SET_BYTES) + AW'(k[KW-1:0]);
               mem_we  = 1'b1;
               pend_in = '{valid: 1'b1, finish: ctl.finish, set: cur_v, data: b0,
                           beyond: (k >= stored_len_ff[cur_v])};
            end
            if (k != SAT24)
               len_v[cur_v] = k + 24'd1;
         end
      end

      // summary of the unit as it stands after this visit
      for (int s = 0; s < 3; s++)
         sum.changed[s] = pres_v[s] & (mis_v[s] | (len_v[s] != stored_len_ff[s]));
      sum.present   = pres_v;
      sum.nal_count = nal_v;

      // commit present sets and clear the unit at its end
      stored_len_in = stored_len_ff;
      sel_in        = sel_ff;
      if (ctl.visit && ctl.finish) begin
         for (int s = 0; s < 3; s++) begin
            if (pres_v[s]) begin
               stored_len_in[s] = len_v[s];
               sel_in[s]        = ~sel_ff[s];
            end
         end
         skip_in     = 3'd0;
         cur_in      = SET_NONE;
         pres_in     = 3'b000;
         mis_in      = 3'b000;
         nal_in      = 8'd0;
         cand_len_in = '{default: 24'd0};
      end else begin
         skip_in     = skip_v;
         cur_in      = cur_v;
         pres_in     = pres_v;
         mis_in      = mis_v;
         nal_in      = nal_v;
         cand_len_in = len_v;
      end
   end

   // set byte memory
   always_ff @(posedge clock) begin
      if (mem_we)
         set_mem[waddr] <= wdata;
      rd_ff <= set_mem[raddr];
   end

   // scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= '0;
         skip_ff       <= 3'd0;
         cur_ff        <= SET_NONE;
         pres_ff       <= 3'b000;
         mis_ff        <= 3'b000;
         nal_ff        <= 8'd0;
         cand_len_ff   <= '{default: 24'd0};
         stored_len_ff <= '{default: 24'd0};
         sel_ff        <= 3'b000;
      end else begin
         pend_ff       <= pend_in;
         skip_ff       <= skip_in;
         cur_ff        <= cur_in;
         pres_ff       <= pres_in;
         mis_ff        <= mis_in;
         nal_ff        <= nal_in;
         cand_len_ff   <= cand_len_in;
         stored_len_ff <= stored_len_in;
         sel_ff        <= sel_in;
      end
   end

endmodule

`default_nettype wire

// File: src/hevc_param_set_change_detector_unit.sv
// Result path: a unit's last byte visit fills the finishing stage, then the result
// register; that byte trails the input by up to four bytes of lookahead. Throughput:
// one byte per cycle unless a last byte waits on the result path, set by the
// single scanner visit and one memory read and write port; queue absorbs unit tails.
// Reset: synchronous; clears counters, stored set lengths and the queue.
// ----------------------------------------------------------------------------
// hevc_param_set_change_detector_unit
// Annex B byte stream scanner reporting VPS/SPS/PPS changes per access unit.
// ----------------------------------------------------------------------------
`default_nettype none

module hevc_param_set_change_detector_unit
   import hpscd_pkg::*;
#(
   parameter int MAX_SET_BYTES = MAX_SET_BYTES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [23:0]  req_tdata,   // data_byte[7:0], packet_id[23:8]
   input  wire logic         req_tlast,   // last_of_au
   input  wire logic [1:0]   req_tuser,   // first_of_au[0], is_keyframe[1]
   // result channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [119:0]      rsp_tdata,   // au_count[31:0], ps_au_count[63:32],
                                          // aus_since_switch[79:64], report[80],
                                          // keyframe_out[81], au_size[105:82],
                                          // nal_count[113:106], has_param_sets[114],
                                          // vps/sps/pps_changed[117:115], zero[119:118]
   // configuration
   input  wire logic         csr_wen,
   input  wire logic [7:0]   csr_wdata
);

   logic [7:0]  window_ff;
   logic        pid_seen_ff;
   logic [15:0] pid_ff;
   logic [15:0] since_ff, since_in;
   logic [23:0] pos_ff, pos_in;

   q_entry_type       q_ff [QUEUE_DEPTH];
   q_entry_type       q_in [QUEUE_DEPTH];
   logic [QCNT_W-1:0] qcnt_ff, qcnt_in;

   logic        f_valid_ff;
   logic [2:0]  f_pres_ff, f_chg_ff;
   logic [7:0]  f_nal_ff;
   logic [31:0] f_au_ff, f_ps_ff;
   logic [15:0] f_since_ff;
   logic [23:0] f_size_ff;
   logic        f_key_ff;
   logic [31:0] au_cnt_ff, ps_cnt_ff;

   logic        rsp_valid_ff;
   logic [31:0] o_au_ff, o_ps_ff;
   logic [15:0] o_since_ff;
   logic        o_report_ff, o_key_ff, o_hasps_ff;
   logic [23:0] o_size_ff;
   logic [7:0]  o_nal_ff;
   logic [2:0]  o_chg_ff;

   logic          accept;
   logic          req_first, req_key;
   logic [15:0]   req_pid;
   q_entry_type   new_entry;
   logic          decidable, pop, fin_pop;
   scan_mode_type mode;
   logic          out_free, f_free, f_move;
   logic [2:0]    f_chg_eff;
   scan_ctl_type  ctl;
   scan_sum_type  sum;
   scan_late_type late;

   assign req_tready = (qcnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign accept     = req_tvalid & req_tready;
   assign req_first  = req_tuser[0];
   assign req_key    = req_tuser[1];
   assign req_pid    = req_tdata[23:8];

   // byte count and packet id tracking at the request side
   always_comb begin
      logic [15:0] since_a;
      logic [15:0] since_l;
      logic [23:0] pos_a;
      logic [23:0] pos_b;

      since_a = (!pid_seen_ff || req_pid != pid_ff) ? 16'd0 : since_ff;
      since_l = (since_a == SINCE_MAX) ? SINCE_MAX : since_a + 16'd1;
      pos_a   = req_first ? 24'd0 : pos_ff;
      pos_b   = (pos_a == SAT24) ? SAT24 : pos_a + 24'd1;

      since_in  = req_tlast ? since_l : since_a;
      pos_in    = req_tlast ? 24'd0 : pos_b;
      new_entry = '{data: req_tdata[7:0], first: req_first, last: req_tlast,
                    key: req_key, size: pos_b, since: since_l};
   end

   // head decision: enough lookahead or the unit has ended
   always_comb begin
      decidable = 1'b0;
      mode      = MODE_FULL;
      if (qcnt_ff != '0) begin
         if (q_ff[0].last) begin
            decidable = 1'b1;
            mode      = MODE_NONE;
         end else if (qcnt_ff >= QCNT_W'(2) && q_ff[1].last) begin
            decidable = 1'b1;
            mode      = MODE_NONE;
         end else if (qcnt_ff >= QCNT_W'(3) && q_ff[2].last) begin
            decidable = 1'b1;
            mode      = MODE_NONE;
         end else if (qcnt_ff >= QCNT_W'(4) && q_ff[3].last) begin
            decidable = 1'b1;
            mode      = MODE_SHORT;
         end else if (qcnt_ff >= QCNT_W'(5)) begin
            decidable = 1'b1;
            mode      = MODE_FULL;
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign f_free   = !f_valid_ff || out_free;
   assign f_move   = f_valid_ff && out_free;
   assign pop      = decidable && (!q_ff[0].last || f_free);
   assign fin_pop  = pop && q_ff[0].last;

   assign ctl = '{visit: pop, restart: q_ff[0].first, finish: q_ff[0].last, mode: mode};

   // queue update: pop head, drop an unfinished unit on a first byte, push
   always_comb begin
      logic [QCNT_W-1:0] keep;
      logic [QCNT_W-1:0] base;
      logic [QCNT_W-1:0] nbase;

      keep = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++)
         if (QCNT_W'(i) < qcnt_ff && q_ff[i].last)
            keep = QCNT_W'(i + 1);
      base  = (accept && req_first) ? keep : qcnt_ff;
      nbase = (pop && base != '0) ? base - QCNT_W'(1) : base;

      for (int i = 0; i < QUEUE_DEPTH - 1; i++)
         q_in[i] = pop ? q_ff[i + 1] : q_ff[i];
      q_in[QUEUE_DEPTH - 1] = q_ff[QUEUE_DEPTH - 1];
      if (accept)
         q_in[nbase[QIW-1:0]] = new_entry;
      qcnt_in = nbase + QCNT_W'(accept);
   end

   hpscd_scan #(
      .MAX_SET_BYTES (MAX_SET_BYTES)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .window ({q_ff[0].data, q_ff[1].data, q_ff[2].data, q_ff[3].data, q_ff[4].data}),
      .sum    (sum),
      .late   (late)
   );

   assign f_chg_eff = f_chg_ff | (late.valid ? late.changed : 3'b000);

   // request side state and queue
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= REPORT_WINDOW_RST;
         pid_seen_ff <= 1'b0;
         pid_ff      <= 16'd0;
         since_ff    <= 16'd0;
         pos_ff      <= 24'd0;
         qcnt_ff     <= '0;
      end else begin
         if (csr_wen)
            window_ff <= csr_wdata;
         if (accept) begin
            pid_seen_ff <= 1'b1;
            pid_ff      <= req_pid;
            since_ff    <= since_in;
            pos_ff      <= pos_in;
         end
         qcnt_ff <= qcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   // finishing stage and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff   <= 1'b0;
         au_cnt_ff    <= 32'd0;
         ps_cnt_ff    <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fin_pop) begin
            au_cnt_ff <= au_cnt_ff + 32'd1;
            if (sum.present != 3'b000)
               ps_cnt_ff <= ps_cnt_ff + 32'd1;
         end
         if (fin_pop)
            f_valid_ff <= 1'b1;
         else if (f_move)
            f_valid_ff <= 1'b0;
         if (f_move)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_pop) begin
         f_pres_ff  <= sum.present;
         f_chg_ff   <= sum.changed;
         f_nal_ff   <= sum.nal_count;
         f_au_ff    <= au_cnt_ff + 32'd1;
         f_ps_ff    <= ps_cnt_ff + ((sum.present != 3'b000) ? 32'd1 : 32'd0);
         f_since_ff <= q_ff[0].since;
         f_size_ff  <= q_ff[0].size;
         f_key_ff   <= q_ff[0].key;
      end else begin
         f_chg_ff <= f_chg_eff;
      end
      if (f_move) begin
         o_au_ff     <= f_au_ff;
         o_ps_ff     <= f_ps_ff;
         o_since_ff  <= f_since_ff;
         o_report_ff <= (f_since_ff <= {8'd0, window_ff}) || (f_chg_eff != 3'b000);
         o_key_ff    <= f_key_ff;
         o_size_ff   <= f_size_ff;
         o_nal_ff    <= f_nal_ff;
         o_hasps_ff  <= (f_pres_ff != 3'b000);
         o_chg_ff    <= f_chg_eff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, o_chg_ff, o_hasps_ff, o_nal_ff, o_size_ff, o_key_ff,
                        o_report_ff, o_since_ff, o_ps_ff, o_au_ff};

endmodule

`default_nettype wire
